// File: src/kwm_pkg.sv
package kwm_pkg;

    typedef enum logic [0:0] {
        K_APPEND = 1'b0,
        K_TAKE   = 1'b1
    } kwm_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } kwm_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_APPEND,
        B_SCAN,
        B_POP,
        B_LOAD,
        B_RESP
    } kwm_state_t;

    localparam int SEL_WIDTH = 3;

    typedef struct packed {
        kwm_kind_t             kind;
        logic [SEL_WIDTH-1:0]  sel;
    } kwm_cmd_t;

endpackage

// File: src/kwm_ram.sv
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/kwm_front.sv
module kwm_front #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [((KEY_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic [3:0]                     s_tuser,
    output logic                           cmd_valid,
    input  logic                           cmd_pop,
    output kwm_pkg::kwm_cmd_t              cmd,
    output logic [KEY_WIDTH-1:0]           cmd_key
);
    import kwm_pkg::*;

    kwm_cmd_t             q_cmd_reg [2];
    logic [KEY_WIDTH-1:0] q_key_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           cnt_reg;
    logic                 push;
    kwm_cmd_t             in_cmd;

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_cmd_reg[rd_ptr_reg];
    assign cmd_key   = q_key_reg[rd_ptr_reg];

    always_comb
    begin
        in_cmd.kind = kwm_kind_t'(s_tuser[0]);
        in_cmd.sel  = s_tuser[3:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !cmd_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!push && cmd_pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd_reg[wr_ptr_reg] <= in_cmd;
            q_key_reg[wr_ptr_reg] <= s_tdata[KEY_WIDTH-1:0];
        end
    end

endmodule

// File: src/kwm_back.sv
module kwm_back #(
    parameter int MAX_LISTS  = 8,
    parameter int LIST_DEPTH = 256,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [3:0]                     cfg_wdata,
    input  logic                           cmd_valid,
    output logic                           cmd_pop,
    input  kwm_pkg::kwm_cmd_t              cmd,
    input  logic [KEY_WIDTH-1:0]           cmd_key,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [((KEY_WIDTH+3+7)/8)*8-1:0] m_tdata,
    output logic [1:0]                     m_tuser
);
    import kwm_pkg::*;

    localparam int LW        = $clog2(MAX_LISTS);
    localparam int CW        = $clog2(MAX_LISTS + 1);
    localparam int AW        = $clog2(LIST_DEPTH);
    localparam int NW        = $clog2(LIST_DEPTH + 1);
    localparam int RAW       = $clog2(MAX_LISTS * LIST_DEPTH);
    localparam int ODW       = ((KEY_WIDTH + 3 + 7) / 8) * 8;
    localparam int LISTS_RST = (MAX_LISTS < 8) ? MAX_LISTS : 8;

    kwm_state_t                  state_reg, state_next;
    kwm_kind_t                   kind_reg;
    logic [SEL_WIDTH-1:0]        sel_reg;
    logic signed [KEY_WIDTH-1:0] key_reg;
    logic [LW-1:0]               scan_reg;
    logic                        found_reg;
    logic [LW-1:0]               best_reg;
    logic signed [KEY_WIDTH-1:0] best_key_reg;
    kwm_status_t                 status_reg;
    logic [CW-1:0]               lists_reg;

    logic [NW-1:0]               cnt_reg  [MAX_LISTS];
    logic [AW-1:0]               rd_reg   [MAX_LISTS];
    logic [AW-1:0]               wr_reg   [MAX_LISTS];
    logic signed [KEY_WIDTH-1:0] head_reg [MAX_LISTS];
    logic [MAX_LISTS-1:0]        nonempty;

    logic                        m_valid_reg;
    logic signed [KEY_WIDTH-1:0] m_key_reg;
    logic [SEL_WIDTH-1:0]        m_src_reg;
    kwm_status_t                 m_status_reg;

    logic [LW-1:0]               cur;
    logic                        sel_ok;
    logic                        list_full;
    logic                        scan_last;
    logic                        scan_hit;
    logic                        remain;
    logic [AW-1:0]               rd_inc;
    logic [AW-1:0]               wr_inc;
    logic                        ram_we;
    logic                        out_load;
    logic [RAW-1:0]              ram_waddr;
    logic [RAW-1:0]              ram_raddr;
    logic [KEY_WIDTH-1:0]        ram_rdata;
    logic [CW-1:0]               lists_next;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LISTS; gi++)
        begin : g_ne
            assign nonempty[gi] = (cnt_reg[gi] != '0);
        end
    endgenerate

    assign cur       = LW'(sel_reg);
    assign sel_ok    = (32'(sel_reg) < 32'(MAX_LISTS));
    assign list_full = sel_ok && (32'(cnt_reg[cur]) == 32'(LIST_DEPTH));
    assign scan_last = ((CW'(scan_reg) + CW'(1)) == lists_reg);
    assign scan_hit  = nonempty[scan_reg] && (!found_reg || (head_reg[scan_reg] < best_key_reg));
    assign remain    = (cnt_reg[best_reg] != NW'(1));
    assign rd_inc    = (32'(rd_reg[best_reg]) == 32'(LIST_DEPTH - 1)) ? '0
                                                                      : rd_reg[best_reg] + AW'(1);
    assign wr_inc    = (32'(wr_reg[cur]) == 32'(LIST_DEPTH - 1)) ? '0 : wr_reg[cur] + AW'(1);
    assign ram_waddr = RAW'(cur) * RAW'(LIST_DEPTH) + RAW'(wr_reg[cur]);
    assign ram_raddr = RAW'(best_reg) * RAW'(LIST_DEPTH) + RAW'(rd_inc);

    always_comb
    begin
        if (cfg_wdata == 4'd0)
        begin
            lists_next = CW'(1);
        end
        else if (32'(cfg_wdata) > 32'(MAX_LISTS))
        begin
            lists_next = CW'(MAX_LISTS);
        end
        else
        begin
            lists_next = CW'(cfg_wdata);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.kind == K_APPEND) ? B_APPEND : B_SCAN;
                end
            end
            B_APPEND: state_next = B_RESP;
            B_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = (found_reg || scan_hit) ? B_POP : B_RESP;
                end
            end
            B_POP:    state_next = remain ? B_LOAD : B_RESP;
            B_LOAD:   state_next = B_RESP;
            B_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop  = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            B_IDLE:   cmd_pop  = cmd_valid;
            B_APPEND: ram_we   = sel_ok && !list_full;
            B_RESP:   out_load = !m_valid_reg || m_tready;
            default:  ;
        endcase
    end

    kwm_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (MAX_LISTS * LIST_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            lists_reg   <= CW'(LISTS_RST);
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            for (int i = 0; i < MAX_LISTS; i++)
            begin
                cnt_reg[i] <= '0;
                rd_reg[i]  <= '0;
                wr_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                lists_reg <= lists_next;
            end
            if (cmd_pop)
            begin
                found_reg <= 1'b0;
            end
            else if (state_reg == B_SCAN && scan_hit)
            begin
                found_reg <= 1'b1;
            end
            if (ram_we)
            begin
                cnt_reg[cur] <= cnt_reg[cur] + NW'(1);
                wr_reg[cur]  <= wr_inc;
            end
            if (state_reg == B_POP)
            begin
                cnt_reg[best_reg] <= cnt_reg[best_reg] - NW'(1);
                rd_reg[best_reg]  <= rd_inc;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            kind_reg <= cmd.kind;
            sel_reg  <= cmd.sel;
            key_reg  <= cmd_key;
            scan_reg <= '0;
        end
        if (state_reg == B_SCAN)
        begin
            scan_reg <= scan_reg + LW'(1);
            if (scan_hit)
            begin
                best_reg     <= scan_reg;
                best_key_reg <= head_reg[scan_reg];
            end
        end
        if (state_reg == B_APPEND)
        begin
            status_reg <= (!sel_ok || list_full) ? ST_FULL : ST_OK;
        end
        if (state_reg == B_SCAN && scan_last)
        begin
            status_reg <= (found_reg || scan_hit) ? ST_OK : ST_EMPTY;
        end
        if (ram_we && !nonempty[cur])
        begin
            head_reg[cur] <= key_reg;
        end
        else if (state_reg == B_LOAD)
        begin
            head_reg[best_reg] <= ram_rdata;
        end
        if (out_load)
        begin
            m_status_reg <= status_reg;
            if (kind_reg == K_TAKE && status_reg == ST_OK)
            begin
                m_key_reg <= best_key_reg;
                m_src_reg <= SEL_WIDTH'(best_reg);
            end
            else
            begin
                m_key_reg <= '0;
                m_src_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ODW'({m_src_reg, m_key_reg});
    assign m_tuser  = m_status_reg;

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_POP) |-> nonempty[best_reg])
        else $error("pop from an empty list");

    a_pop_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_POP) |-> (CW'(best_reg) < lists_reg))
        else $error("pop from a list outside the merge");

    a_load_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LOAD) |-> ($past(state_reg) == B_POP))
        else $error("head load without pop");

    a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == B_APPEND || state_reg == B_SCAN))
        else $error("command taken but not dispatched");
`endif

endmodule

// File: src/k_way_sorted_list_merge.sv
// K-way merge of sorted lists.
// Input stream (s_*): one beat per command. s_tuser[0] is the opcode (0 append,
// 1 take), s_tuser[3:1] the target list of an append, s_tdata the key.
// Output stream (m_*): one result beat per command: m_tdata holds the taken
// key and its source list, m_tuser the status (0 ok, 1 append dropped because
// the list is full or does not exist, 2 take with every list in use empty).
// cfg_we/cfg_wdata set how many lists take part (0 acts as 1, values above
// MAX_LISTS act as MAX_LISTS); write it only while the block is idle.
// Sequence: an append goes from the queue through the append step to the output
// register; a take runs the head scan, which compares one list head per cycle over
// the lists in use, then pops the winning list and reads the store for its next head.
// One command executes at a time, so the back end takes no new command until
// the result of the last one is in the output register.
// A two-beat command queue keeps accepting while a command executes or
// while a result waits; when the receiver stalls, the result holds in the
// output register and the back end waits, then the queue fills and s_tready
// drops. Reset empties all lists and the queue, lists_in_use = min(8, MAX_LISTS).
module k_way_sorted_list_merge #(
    parameter int MAX_LISTS  = 8,
    parameter int LIST_DEPTH = 256,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [3:0]                       cfg_wdata,    // lists_in_use
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((KEY_WIDTH+7)/8)*8-1:0]   s_tdata,      // key_value
    input  logic [3:0]                       s_tuser,      // opcode, list_select
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [((KEY_WIDTH+3+7)/8)*8-1:0] m_tdata,      // merged_key, source_list
    output logic [1:0]                       m_tuser       // status
);
    import kwm_pkg::*;

    logic                 cmd_valid;
    logic                 cmd_pop;
    kwm_cmd_t             cmd;
    logic [KEY_WIDTH-1:0] cmd_key;

    kwm_front #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_key   (cmd_key)
    );

    kwm_back #(
        .MAX_LISTS  (MAX_LISTS),
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_key   (cmd_key),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
